### rtl/modexp_pkg.sv
package modexp_pkg;

  // Default operand width of the exponentiation datapath.
  localparam int unsigned DefaultWidth = 32;

  // Operation carried out by the shared shift-add modular multiplier.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,  // base mod modulus, computed as 1 * base
    OP_MULT   = 2'd1,  // running result times current base
    OP_SQUARE = 2'd2   // current base squared
  } op_e;

endpackage

### rtl/modular_exponentiation.sv
// Modular exponentiation, residue = base_value ^ power mod modulus.
// The input channel carries one beat per operation: base_value_i, power_i and
// modulus_i, taken at a rising edge where in_valid_i is high and in_stall_o is
// low. The output channel returns one beat per input beat: residue_o and
// zero_modulus_o, taken where out_valid_o is high and out_stall_i is low.
// A modulus of zero returns a residue of zero with zero_modulus_o set; a
// modulus of one returns zero.
// The block works on one beat at a time. One shared shift-add modular
// multiplier handles one multiplier bit per cycle. A beat costs one
// reduction of the base, then one squaring per exponent bit below the top set
// bit and one multiplication per set bit. A modulus of zero or one skips the
// multiplier. The input stays stalled until the result moves into the output
// register, and only then can the next beat be accepted.
// The output register lets a new beat be accepted while the previous result
// still waits; if a finished result meets a full, stalled output register, it
// holds in place until the receiver takes the older beat.
// Reset clears the sequencer and the output valid flag; nothing else is kept
// between beats.
module modular_exponentiation #(
  parameter int unsigned WIDTH = modexp_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] base_value_i,
  input  logic [WIDTH-1:0] power_i,
  input  logic [WIDTH-1:0] modulus_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WIDTH-1:0] residue_o,
  output logic             zero_modulus_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // (x + y) mod m for x, y below m; never forms a value above m.
  function automatic logic [WIDTH-1:0] add_mod(
    input logic [WIDTH-1:0] x,
    input logic [WIDTH-1:0] y,
    input logic [WIDTH-1:0] m
  );
    logic [WIDTH-1:0] gap;
    gap = m - y;
    if (x >= gap) begin
      return x - gap;
    end
    return x + y;
  endfunction

  logic [1:0]       state_q, state_d;
  modexp_pkg::op_e  op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] base_q, base_d;     // current base, reduced
  logic [WIDTH-1:0] exp_q, exp_d;       // remaining exponent bits
  logic [WIDTH-1:0] mod_q, mod_d;
  logic [WIDTH-1:0] acc_q, acc_d;       // running result
  logic             zm_q, zm_d;
  logic [WIDTH-1:0] mul_a_q, mul_a_d;   // multiplicand
  logic [WIDTH-1:0] mul_b_q, mul_b_d;   // multiplier, scanned from its top bit
  logic [WIDTH-1:0] mul_p_q, mul_p_d;   // partial product, kept below the modulus
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] residue_q, residue_d;
  logic             zero_q, zero_d;

  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] prod_next;
  logic             in_accept;
  logic             out_free;
  logic [WIDTH-1:0] exp_shift;

  // Shared unit: one multiplier bit per cycle, double then conditionally add.
  always_comb begin
    dbl       = add_mod(mul_p_q, mul_p_q, mod_q);
    prod_next = mul_b_q[WIDTH-1] ? add_mod(dbl, mul_a_q, mod_q) : dbl;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exp_shift  = exp_q >> 1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    zm_d        = zm_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_p_d     = mul_p_q;
    out_valid_d = out_valid_q && out_stall_i;
    residue_d   = residue_q;
    zero_d      = zero_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          exp_d = power_i;
          mod_d = modulus_i;
          if (modulus_i == '0) begin
            acc_d   = '0;
            zm_d    = 1'b1;
            state_d = S_DONE;
          end else if (modulus_i == WIDTH'(1)) begin
            acc_d   = '0;
            zm_d    = 1'b0;
            state_d = S_DONE;
          end else begin
            // The base is reduced as the product 1 * base.
            zm_d    = 1'b0;
            op_d    = modexp_pkg::OP_REDUCE;
            mul_a_d = WIDTH'(1);
            mul_b_d = base_value_i;
            mul_p_d = '0;
            cnt_d   = CntW'(WIDTH - 1);
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        mul_p_d = prod_next;
        mul_b_d = mul_b_q << 1;
        cnt_d   = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          mul_p_d = '0;
          cnt_d   = CntW'(WIDTH - 1);
          unique case (op_q)
            modexp_pkg::OP_REDUCE: begin
              base_d = prod_next;
              acc_d  = WIDTH'(1);
              if (exp_q == '0) begin
                state_d = S_DONE;
              end else if (exp_q[0]) begin
                op_d    = modexp_pkg::OP_MULT;
                mul_a_d = WIDTH'(1);
                mul_b_d = prod_next;
              end else begin
                op_d    = modexp_pkg::OP_SQUARE;
                mul_a_d = prod_next;
                mul_b_d = prod_next;
              end
            end
            modexp_pkg::OP_MULT: begin
              acc_d = prod_next;
              // No squaring is needed once no higher exponent bit is set.
              if (exp_shift == '0) begin
                state_d = S_DONE;
              end else begin
                op_d    = modexp_pkg::OP_SQUARE;
                mul_a_d = base_q;
                mul_b_d = base_q;
              end
            end
            modexp_pkg::OP_SQUARE: begin
              base_d = prod_next;
              exp_d  = exp_shift;
              if (exp_shift == '0) begin
                state_d = S_DONE;
              end else if (exp_shift[0]) begin
                op_d    = modexp_pkg::OP_MULT;
                mul_a_d = acc_q;
                mul_b_d = prod_next;
              end else begin
                op_d    = modexp_pkg::OP_SQUARE;
                mul_a_d = prod_next;
                mul_b_d = prod_next;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          residue_d   = acc_q;
          zero_d      = zm_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= modexp_pkg::OP_REDUCE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    exp_q     <= exp_d;
    mod_q     <= mod_d;
    acc_q     <= acc_d;
    zm_q      <= zm_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_p_q   <= mul_p_d;
    residue_q <= residue_d;
    zero_q    <= zero_d;
  end

  assign out_valid_o    = out_valid_q;
  assign residue_o      = residue_q;
  assign zero_modulus_o = zero_q;

  // A flagged zero modulus always comes with a zero residue.
  a_zero_mod_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_modulus_o |-> residue_o == '0)
    else $error("zero modulus beat with nonzero residue");

  // An accepted beat always starts work.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE)
    else $error("accepted beat did not leave idle");

  // The partial product stays reduced while the shared unit runs.
  a_partial_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> mul_p_q < mod_q)
    else $error("partial product not below modulus");

  // The running result stays reduced while work goes on.
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN && op_q != modexp_pkg::OP_REDUCE |-> acc_q < mod_q)
    else $error("running result not below modulus");

  // A new output beat appears only when a finished result is handed over.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("output beat raised outside the hand-over state");

endmodule

### dv/modular_exponentiation_tb.sv
`timescale 1ns / 1ps

module modular_exponentiation_tb;

  // The operand width follows the package default so that the ports match the block.
  localparam int unsigned WIDTH = modexp_pkg::DefaultWidth;

  // Each accepted beat has a chance of starting an idle burst, whose length MaxBurst bounds.
  localparam int unsigned MaxBurst    = 12;
  localparam int unsigned RandomBeats = 280;
  // The receiver holds off long enough for a result to wait in the output register
  // while a second one finishes behind it and the input stays stalled.
  localparam int unsigned HoldOffCycles = 6000;
  // Once every expected result is checked, a short tail still catches any extra result beat.
  localparam int unsigned DrainCycles   = 50;
  localparam int unsigned ReportLimit   = 10;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    word_t base_value;
    word_t power;
    word_t modulus;
  } exp_request_t;

  typedef struct packed {
    word_t residue;
    logic  zero_modulus;
  } exp_result_t;

  // Clock, reset and DUT pins. Every input starts at a known value at time zero.
  logic  clk_i;
  logic  rst_ni       = 1'b0;
  logic  in_valid_i   = 1'b0;
  logic  in_stall_o;
  word_t base_value_i = '0;
  word_t power_i      = '0;
  word_t modulus_i    = '0;
  logic  out_valid_o;
  logic  out_stall_i  = 1'b0;
  word_t residue_o;
  logic  zero_modulus_o;

  modular_exponentiation #(
    .WIDTH(WIDTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .base_value_i  (base_value_i),
    .power_i       (power_i),
    .modulus_i     (modulus_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .residue_o     (residue_o),
    .zero_modulus_o(zero_modulus_o)
  );

  // Period of 4 ns: two ns low, two ns high.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Requests waiting to be driven, and residues expected back in order.
  exp_request_t request_q[$];
  exp_result_t  residue_q[$];

  int unsigned  total_requests  = 0;
  int unsigned  accepted_count  = 0;
  int unsigned  mismatch_count  = 0;
  logic         in_beat_taken   = 1'b0;
  logic         idling_enabled  = 1'b1;
  logic         hold_off        = 1'b0;
  int unsigned  source_gap      = 0;
  int unsigned  sink_gap        = 0;
  logic         sink_stall;
  exp_request_t next_request;
  exp_result_t  expected_result;

  // Right-to-left square-and-multiply. Operands are below 2**WIDTH, so every product
  // fits exactly in double width before it is reduced.
  function automatic exp_result_t compute_modexp(exp_request_t req);
    exp_result_t     res;
    logic [2*WIDTH-1:0] running;
    logic [2*WIDTH-1:0] square;
    logic [2*WIDTH-1:0] modulus_wide;
    res.zero_modulus = 1'b0;
    res.residue      = '0;
    if (req.modulus == '0) begin
      // Reduction by zero is undefined, so the block flags it and returns zero.
      res.zero_modulus = 1'b1;
      return res;
    end
    if (req.modulus == word_t'(1)) begin
      // Everything is congruent to zero modulo one, even with a zero exponent.
      return res;
    end
    modulus_wide = {{WIDTH{1'b0}}, req.modulus};
    square       = {{WIDTH{1'b0}}, req.base_value} % modulus_wide;
    running      = (2*WIDTH)'(1);
    for (int i = 0; i < WIDTH; i++) begin
      if (req.power[i]) begin
        running = (running * square) % modulus_wide;
      end
      square = (square * square) % modulus_wide;
    end
    res.residue = running[WIDTH-1:0];
    return res;
  endfunction

  task automatic queue_request(word_t base_value, word_t power, word_t modulus);
    exp_request_t req;
    req.base_value = base_value;
    req.power      = power;
    req.modulus    = modulus;
    request_q.push_back(req);
  endtask

  // Random operand whose significant length is itself random, from 1 to max_bits.
  function automatic word_t random_short(int unsigned max_bits);
    int unsigned bits;
    word_t       value;
    bits  = $urandom_range(max_bits, 1);
    value = word_t'($urandom());
    if (bits < WIDTH) begin
      value = value & ((word_t'(1) << bits) - word_t'(1));
    end
    return value;
  endfunction

  // Sender. Inputs change on the falling edge. A new beat is presented only once
  // the previous one was taken, so a stalled payload never moves.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      if (in_beat_taken && idling_enabled && $urandom_range(3, 0) == 0) begin
        source_gap = $urandom_range(MaxBurst, 1);
      end
      if (source_gap > 0) begin
        source_gap = source_gap - 1;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        next_request = request_q.pop_front();
        in_valid_i   <= 1'b1;
        base_value_i <= next_request.base_value;
        power_i      <= next_request.power;
        modulus_i    <= next_request.modulus;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall. Short random bursts while idling is enabled, plus the long
  // hold-off that the pressure process asks for.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      sink_stall = 1'b0;
      if (sink_gap > 0) begin
        sink_gap   = sink_gap - 1;
        sink_stall = 1'b1;
      end else if (idling_enabled && $urandom_range(7, 0) == 0) begin
        sink_gap   = $urandom_range(MaxBurst - 1, 0);
        sink_stall = 1'b1;
      end
      out_stall_i <= sink_stall || hold_off;
    end
  end

  // Input side of the monitor: an accepted beat is turned into its expected result
  // straight from the pins, which are stable since the last falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        residue_q.push_back(compute_modexp({base_value_i, power_i, modulus_i}));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Output side of the monitor: each accepted result beat is compared against the
  // oldest expectation. Only the first few problems are printed in full.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (residue_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= ReportLimit) begin
          $display("[%0t] unexpected result beat: residue %h zero_modulus %b",
                   $realtime, residue_o, zero_modulus_o);
        end
      end else begin
        expected_result = residue_q.pop_front();
        if (residue_o !== expected_result.residue
            || zero_modulus_o !== expected_result.zero_modulus) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= ReportLimit) begin
            $display("[%0t] mismatch: expected residue %h zero_modulus %b, got %h %b",
                     $realtime, expected_result.residue, expected_result.zero_modulus,
                     residue_o, zero_modulus_o);
          end
        end
      end
    end
  end

  // Pressure: once the run is under way the receiver stops taking results for a long
  // stretch while the sender keeps offering, so the output register fills, a second
  // result waits behind it, and the input stays stalled.
  initial begin
    wait (rst_ni);
    wait (accepted_count >= 60);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // Stimulus, reset and end of test.
  initial begin
    // Modulus of zero: result forced to zero and flagged.
    queue_request('0, '0, '0);
    queue_request('1, '1, '0);
    queue_request(32'd7, 32'd3, '0);
    // Modulus of one: zero for every base, also with a zero exponent.
    queue_request(32'd5, '0, 32'd1);
    queue_request('1, '1, 32'd1);
    // Zero exponent gives one when the modulus exceeds one.
    queue_request(32'd5, '0, '1);
    queue_request('0, '0, 32'd7);
    queue_request('1, '0, 32'd2);
    // Zero base with a nonzero exponent.
    queue_request('0, 32'd5, 32'd13);
    // Base at or above the modulus is reduced first.
    queue_request('1, '1, '1);
    queue_request(32'd13, 32'd4, 32'd13);
    queue_request(32'd1000, 32'd3, 32'd7);
    queue_request('1, '1, 32'hFFFF_FFFE);
    // Largest operands, where the double-width products matter most.
    queue_request(32'hFFFF_FFFE, 32'd2, '1);
    queue_request(32'd2, 32'd31, '1);
    queue_request(32'd3, '1, 32'hFFFF_FFFB);
    queue_request(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFB);
    queue_request('1, 32'd1, 32'h8000_0000);
    queue_request(32'd3, '1, 32'd2);
    queue_request(32'd12345, 32'd1, 32'd97);
    queue_request(32'hDEAD_BEEF, 32'h0123_4567, 32'hFFFF_FFF1);

    // Random part. Full-width exponents make the slowest beats, so most beats
    // use shorter exponents; the full-width quarter still toggles every exponent bit.
    for (int n = 0; n < RandomBeats; n++) begin
      word_t base_value;
      word_t power;
      word_t modulus;
      base_value = ($urandom_range(1, 0) == 0) ? word_t'($urandom()) : random_short(WIDTH);
      power      = ($urandom_range(3, 0) == 0) ? word_t'($urandom()) : random_short(12);
      case ($urandom_range(15, 0))
        0: begin
          modulus = '0;
        end
        1: begin
          modulus = word_t'(1);
        end
        2, 3, 4: begin
          modulus = random_short(8);
        end
        default: begin
          modulus = word_t'($urandom());
        end
      endcase
      queue_request(base_value, power, modulus);
    end
    total_requests = request_q.size();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Idling stops for the last stretch so the tail runs back to back.
    wait (accepted_count + 40 >= total_requests);
    idling_enabled = 1'b0;

    wait (accepted_count == total_requests && residue_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && residue_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run including every stall.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
dv/modular_exponentiation_tb.sv
